// ----- design/bkt_pkg.sv -----
package bkt_pkg;

  // field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KEY_W    = 24;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned ENTRY_W  = KEY_W + VAL_W;

  // most results one list transaction may produce
  localparam int unsigned OUT_LIMIT = 16;
  localparam int unsigned ECNT_W    = $clog2(OUT_LIMIT);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_DELETED = 3'd4,
    ST_ENTRY   = 3'd5,
    ST_EMPTY   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  // one result transaction
  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              last;
  } res_t;

endpackage

// ----- design/bkt_ram.sv -----
module bkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bkt_seq.sv -----
module bkt_seq #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // command side
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bkt_pkg::cmd_t                in_cmd,
  input  logic [bkt_pkg::KEY_W-1:0]    in_key,
  input  logic [bkt_pkg::VAL_W-1:0]    in_value,
  // result side
  output logic                         res_valid,
  input  logic                         res_ready,
  output bkt_pkg::res_t                res,
  // table memory
  output logic                         mem_we,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_waddr,
  output logic [bkt_pkg::ENTRY_W-1:0]  mem_wdata,
  output logic                         mem_re,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_raddr,
  input  logic [bkt_pkg::ENTRY_W-1:0]  mem_rdata
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // physical slot p holds the entry at newest-first position fill-1-p
  bkt_pkg::state_t              state, state_next;
  logic [CW-1:0]                fill, fill_next;
  logic [AW-1:0]                ptr, ptr_next;
  logic [bkt_pkg::ECNT_W-1:0]   ecnt, ecnt_next;
  logic                         del, del_next;
  logic [bkt_pkg::KEY_W-1:0]    key_r, key_next;
  bkt_pkg::res_t                resp, resp_next;

  logic [bkt_pkg::KEY_W-1:0]    rd_key;
  logic [bkt_pkg::VAL_W-1:0]    rd_val;
  logic                         match;
  logic                         at_top;
  logic                         shift_done;
  logic                         list_last;
  logic                         full;
  logic                         empty;

  assign rd_key     = mem_rdata[bkt_pkg::KEY_W-1:0];
  assign rd_val     = mem_rdata[bkt_pkg::ENTRY_W-1:bkt_pkg::KEY_W];
  assign match      = (rd_key == key_r);
  assign at_top     = ((CW'(ptr) + CW'(1)) == fill);
  assign shift_done = ((CW'(ptr) + CW'(2)) == fill);
  assign list_last  = (ptr == '0) || (ecnt == bkt_pkg::ECNT_W'(bkt_pkg::OUT_LIMIT - 1));
  assign full       = (fill == CW'(CAPACITY));
  assign empty      = (fill == '0);

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bkt_pkg::S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    ecnt  <= ecnt_next;
    del   <= del_next;
    key_r <= key_next;
    resp  <= resp_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bkt_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            bkt_pkg::CMD_ADD:    state_next = bkt_pkg::S_RESP;
            bkt_pkg::CMD_SEARCH,
            bkt_pkg::CMD_DELETE: state_next = empty ? bkt_pkg::S_RESP : bkt_pkg::S_SCAN;
            bkt_pkg::CMD_LIST:   state_next = empty ? bkt_pkg::S_RESP : bkt_pkg::S_LIST;
            default:             state_next = bkt_pkg::S_IDLE;
          endcase
        end
      end
      bkt_pkg::S_SCAN: begin
        if (match) begin
          if (!del || at_top) begin
            state_next = bkt_pkg::S_RESP;
          end else begin
            state_next = bkt_pkg::S_SHIFT;
          end
        end else if (ptr == '0) begin
          state_next = bkt_pkg::S_RESP;
        end
      end
      bkt_pkg::S_SHIFT: begin
        if (shift_done) begin
          state_next = bkt_pkg::S_RESP;
        end
      end
      bkt_pkg::S_LIST: begin
        if (res_ready && list_last) begin
          state_next = bkt_pkg::S_IDLE;
        end
      end
      bkt_pkg::S_RESP: begin
        if (res_ready) begin
          state_next = bkt_pkg::S_IDLE;
        end
      end
      default: state_next = bkt_pkg::S_IDLE;
    endcase
  end

  // outputs, memory control and datapath updates
  always_comb begin
    in_ready   = (state == bkt_pkg::S_IDLE);
    res_valid  = 1'b0;
    res        = resp;
    mem_we     = 1'b0;
    mem_waddr  = ptr;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = ptr;
    fill_next  = fill;
    ptr_next   = ptr;
    ecnt_next  = ecnt;
    del_next   = del;
    key_next   = key_r;
    resp_next  = resp;

    unique case (state)
      bkt_pkg::S_IDLE: begin
        if (in_valid) begin
          key_next  = in_key;
          del_next  = (in_cmd == bkt_pkg::CMD_DELETE);
          ecnt_next = '0;
          ptr_next  = AW'(fill - CW'(1));
          mem_raddr = AW'(fill - CW'(1));
          resp_next = '{status: bkt_pkg::ST_MISSING, key: '0, value: '0, last: 1'b1};
          unique case (in_cmd)
            bkt_pkg::CMD_ADD: begin
              if (full) begin
                resp_next.status = bkt_pkg::ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = AW'(fill);
                mem_wdata        = {in_value, in_key};
                fill_next        = fill + CW'(1);
                resp_next.status = bkt_pkg::ST_ADDED;
              end
            end
            bkt_pkg::CMD_SEARCH,
            bkt_pkg::CMD_DELETE: begin
              mem_re = !empty;
            end
            bkt_pkg::CMD_LIST: begin
              if (empty) begin
                resp_next.status = bkt_pkg::ST_EMPTY;
              end else begin
                mem_re = 1'b1;
              end
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      // walk from newest to oldest until the key matches or slot 0 has been checked
      bkt_pkg::S_SCAN: begin
        if (match) begin
          if (!del) begin
            resp_next.status = bkt_pkg::ST_FOUND;
            resp_next.key    = rd_key;
            resp_next.value  = rd_val;
          end else begin
            resp_next.status = bkt_pkg::ST_DELETED;
            if (at_top) begin
              fill_next = fill - CW'(1);
            end else begin
              mem_re    = 1'b1;
              mem_raddr = ptr + AW'(1);
            end
          end
        end else if (ptr != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr - AW'(1);
          ptr_next  = ptr - AW'(1);
        end
      end
      // close the gap: slot ptr takes the entry read from slot ptr+1
      bkt_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        if (shift_done) begin
          fill_next = fill - CW'(1);
        end else begin
          ptr_next  = ptr + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(CW'(ptr) + CW'(2));
        end
      end
      // one entry per transaction, read data holds through stalls
      bkt_pkg::S_LIST: begin
        res_valid = 1'b1;
        res       = '{status: bkt_pkg::ST_ENTRY, key: rd_key, value: rd_val,
                      last: list_last};
        if (res_ready && !list_last) begin
          ptr_next  = ptr - AW'(1);
          ecnt_next = ecnt + bkt_pkg::ECNT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = ptr - AW'(1);
        end
      end
      bkt_pkg::S_RESP: begin
        res_valid = 1'b1;
        res       = resp;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/bounded_keyed_table_unit.sv -----
// channel | dir | tdata (low bit up)          | tuser   | tlast
// s_*     | in  | key[23:0], value[55:24]     | cmd     | -
// m_*     | out | found_key[23:0],            | status  | last
//         |     | found_value[55:24]          |         |
//
// search does one memory read per entry scanned from newest to oldest;
// delete scans the same way, then moves each newer entry down one slot at
// one read and one write per cycle. list gives one result per cycle while
// the output is not stalled, each from a registered memory read.
// reset empties the table at once (fill count cleared), no clearing pass.
// a stalled output holds the result register and a sequencer offering a result.
module bounded_keyed_table_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // key[23:0], value[55:24]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // found_key[23:0], found_value[55:24]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                         res_valid;
  logic                         res_ready;
  bkt_pkg::res_t                res;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [bkt_pkg::ENTRY_W-1:0]  mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [bkt_pkg::ENTRY_W-1:0]  mem_rdata;

  // table entries, key in the low bits
  bkt_ram #(
    .WIDTH (bkt_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bkt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (bkt_pkg::cmd_t'(s_tuser)),
    .in_key    (s_tdata[bkt_pkg::KEY_W-1:0]),
    .in_value  (s_tdata[bkt_pkg::ENTRY_W-1:bkt_pkg::KEY_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {res.value, res.key};
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

endmodule

// ----- tb/sv/bounded_keyed_table_unit_tb.sv -----
module bounded_keyed_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 320;

  // shadow copy of the table, tracks contents and the results they cause
  class table_shadow;
    logic [bkt_pkg::KEY_W-1:0] slot_key[TABLE_DEPTH];
    logic [bkt_pkg::VAL_W-1:0] slot_val[TABLE_DEPTH];
    int                        fill;
    bkt_pkg::res_t             pending_results[$];
    int                        errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void push_result(bkt_pkg::status_t s, logic [bkt_pkg::KEY_W-1:0] k,
                              logic [bkt_pkg::VAL_W-1:0] v, logic l);
      bkt_pkg::res_t r;
      r.status = s;
      r.key = k;
      r.value = v;
      r.last = l;
      pending_results.push_back(r);
    endfunction

    // newest slot holding this key, -1 when absent
    function int newest_slot(logic [bkt_pkg::KEY_W-1:0] k);
      for (int i = 0; i < fill; i++) begin
        if (slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    // update the shadow table for one accepted command, queue its results
    function void apply_command(bkt_pkg::cmd_t c, logic [bkt_pkg::KEY_W-1:0] k,
                                logic [bkt_pkg::VAL_W-1:0] v);
      int idx;
      int n;
      case (c)
        bkt_pkg::CMD_ADD: begin
          if (fill >= TABLE_DEPTH) begin
            push_result(bkt_pkg::ST_FULL, '0, '0, 1'b1);
          end else begin
            for (int i = fill; i > 0; i--) begin
              slot_key[i] = slot_key[i-1];
              slot_val[i] = slot_val[i-1];
            end
            slot_key[0] = k;
            slot_val[0] = v;
            fill++;
            push_result(bkt_pkg::ST_ADDED, '0, '0, 1'b1);
          end
        end
        bkt_pkg::CMD_SEARCH: begin
          idx = newest_slot(k);
          if (idx < 0) push_result(bkt_pkg::ST_MISSING, '0, '0, 1'b1);
          else push_result(bkt_pkg::ST_FOUND, slot_key[idx], slot_val[idx], 1'b1);
        end
        bkt_pkg::CMD_DELETE: begin
          idx = newest_slot(k);
          if (idx < 0) begin
            push_result(bkt_pkg::ST_MISSING, '0, '0, 1'b1);
          end else begin
            for (int i = idx; i + 1 < fill; i++) begin
              slot_key[i] = slot_key[i+1];
              slot_val[i] = slot_val[i+1];
            end
            fill--;
            push_result(bkt_pkg::ST_DELETED, '0, '0, 1'b1);
          end
        end
        default: begin
          if (fill == 0) begin
            push_result(bkt_pkg::ST_EMPTY, '0, '0, 1'b1);
          end else begin
            n = (fill > bkt_pkg::OUT_LIMIT) ? bkt_pkg::OUT_LIMIT : fill;
            for (int i = 0; i < n; i++)
              push_result(bkt_pkg::ST_ENTRY, slot_key[i], slot_val[i], i == n - 1);
          end
        end
      endcase
    endfunction

    // compare one output transaction with the oldest queued result
    function void match_result(bkt_pkg::status_t s, logic [bkt_pkg::KEY_W-1:0] k,
                               logic [bkt_pkg::VAL_W-1:0] v, logic l);
      bkt_pkg::res_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d found_key %0h found_value %0h last %0b",
               s, k, v, l);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (exp_r.status !== s) begin
        $error("status expected %0d actual %0d", exp_r.status, s);
        errors++;
      end
      if (exp_r.key !== k) begin
        $error("found_key expected %0h actual %0h", exp_r.key, k);
        errors++;
      end
      if (exp_r.value !== v) begin
        $error("found_value expected %0h actual %0h", exp_r.value, v);
        errors++;
      end
      if (exp_r.last !== l) begin
        $error("last expected %0b actual %0b", exp_r.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // key[23:0], value[55:24]
  logic [1:0]  s_tuser;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // found_key[23:0], found_value[55:24]
  logic [2:0]  m_tuser;   // status[2:0]
  logic        m_tlast;

  table_shadow               shadow;
  int                        src_idle_pct;
  int                        sink_idle_pct;
  int                        stall_cycles;
  logic [bkt_pkg::KEY_W-1:0] key_pool[8];

  bounded_keyed_table_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver backpressure, changes at the falling edge
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_idle_pct);
  end

  // check each accepted result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.match_result(bkt_pkg::status_t'(m_tuser), m_tdata[23:0], m_tdata[55:24],
                          m_tlast);
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one command and wait until it is accepted
  task automatic send_cmd(input bkt_pkg::cmd_t c, input logic [bkt_pkg::KEY_W-1:0] k,
                          input logic [bkt_pkg::VAL_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = 56'({$urandom(), $urandom()});
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {v, k};
    s_tuser = c;
    do @(posedge clk); while (!s_tready);
    shadow.apply_command(c, k, v);
  endtask

  // random commands in stretches that alternately fill and drain the table
  task automatic send_random(input int count);
    int                        r;
    bkt_pkg::cmd_t             c;
    logic [bkt_pkg::KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (((i / 32) % 2) == 0)
        c = (r < 55) ? bkt_pkg::CMD_ADD : (r < 75) ? bkt_pkg::CMD_SEARCH :
            (r < 90) ? bkt_pkg::CMD_DELETE : bkt_pkg::CMD_LIST;
      else
        c = (r < 20) ? bkt_pkg::CMD_ADD : (r < 50) ? bkt_pkg::CMD_SEARCH :
            (r < 88) ? bkt_pkg::CMD_DELETE : bkt_pkg::CMD_LIST;
      if ($urandom_range(99) < 75) k = key_pool[$urandom_range(7)];
      else k = bkt_pkg::KEY_W'($urandom());
      send_cmd(c, k, $urandom());
    end
  endtask

  initial begin
    shadow = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = bkt_pkg::CMD_ADD;
    m_tready = 1'b0;
    stall_cycles = 0;
    src_idle_pct = 9;
    sink_idle_pct = 61;
    key_pool[0] = '0;
    key_pool[1] = 24'hFFFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = bkt_pkg::KEY_W'($urandom());
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table cases
    send_cmd(bkt_pkg::CMD_LIST, '0, '0);
    send_cmd(bkt_pkg::CMD_SEARCH, '0, '0);
    send_cmd(bkt_pkg::CMD_DELETE, 24'hFFFFFF, '0);
    // extreme keys and values, duplicate key
    send_cmd(bkt_pkg::CMD_ADD, '0, '0);
    send_cmd(bkt_pkg::CMD_ADD, 24'hFFFFFF, 32'hFFFFFFFF);
    send_cmd(bkt_pkg::CMD_ADD, '0, 32'hA5A5_5A5A);
    send_cmd(bkt_pkg::CMD_ADD, 24'h800001, 32'h8000_0001);
    send_cmd(bkt_pkg::CMD_SEARCH, '0, 32'hFFFFFFFF);
    send_cmd(bkt_pkg::CMD_SEARCH, 24'hFFFFFF, '0);
    send_cmd(bkt_pkg::CMD_SEARCH, 24'h7FFFFE, '0);
    send_cmd(bkt_pkg::CMD_LIST, 24'hFFFFFF, 32'hFFFFFFFF);
    // delete newest duplicate, older one becomes visible
    send_cmd(bkt_pkg::CMD_DELETE, '0, '0);
    send_cmd(bkt_pkg::CMD_SEARCH, '0, '0);
    send_cmd(bkt_pkg::CMD_DELETE, 24'h123456, '0);
    // delete oldest entry, then the middle one
    send_cmd(bkt_pkg::CMD_DELETE, '0, '0);
    send_cmd(bkt_pkg::CMD_DELETE, 24'hFFFFFF, '0);
    send_cmd(bkt_pkg::CMD_LIST, '0, '0);
    send_cmd(bkt_pkg::CMD_DELETE, 24'h800001, '0);
    send_cmd(bkt_pkg::CMD_LIST, '0, '0);

    send_random(RANDOM_ITEMS / 3);
    src_idle_pct = 61;
    sink_idle_pct = 9;
    send_random(RANDOM_ITEMS / 3);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    @(negedge clk);
    s_tvalid = 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
